// ===== sv/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// No dependencies; every other file of the block imports this package.
package ffba_pkg;

  // Widths of the word fields, fixed by the interface.
  localparam int SLOT_W   = 4;
  localparam int SIZE_W   = 16;
  localparam int COUNT_W  = 5;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_BLOCKS  = 16;
  localparam int DEF_SIZE_BITS   = 16;
  localparam int QUEUE_DEPTH     = 2;

  // Operation codes carried in the mode field.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  // A classified command as it travels from the front end to the back end.
  typedef struct packed {
    logic              op;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

// ===== sv/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: config register, front end, queue, back end.
// Depends on ffba_pkg, ffba_front, ffba_queue and ffba_back.
//
//   Channel   Handshake              Word
//   input     start / busy           in_mode, in_block_slot, in_size_value
//   result    out_strobe (1 cycle)   out_granted, out_block_index, out_remaining
//   config    cfg_we                 cfg_block_count
//
// A load word occupies the back end only while it leaves the queue. An allocate word
// occupies it while it leaves the queue and then while the scan examines blocks, at
// most min(block_count, MAX_BLOCKS) of them; a count of zero answers without a scan.
// The scan reads one table entry per cycle through a single registered read port,
// and that port sets the rate. Reset is synchronous and active low; it empties the
// queue and marks every table entry as zero capacity. The result receiver cannot
// stall; busy rises only while the two-word queue is full.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = ffba_pkg::DEF_SIZE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [ffba_pkg::SLOT_W-1:0]  in_block_slot,
  input  logic [ffba_pkg::SIZE_W-1:0]  in_size_value,
  output logic                         out_strobe,
  output logic                         out_granted,
  output logic [ffba_pkg::SLOT_W-1:0]  out_block_index,
  output logic [ffba_pkg::SIZE_W-1:0]  out_remaining,
  input  logic                         cfg_we,
  input  logic [ffba_pkg::COUNT_W-1:0] cfg_block_count
);
  import ffba_pkg::*;

  localparam int Q_W = $bits(cmd_t) + SIZE_BITS;

  // Block count register: the user writes it only while the block is idle; unenforced.
  logic [COUNT_W-1:0] block_count_r, block_count_nxt;

  logic                 push;
  cmd_t                 f_cmd;
  logic [SIZE_BITS-1:0] f_size;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  logic [Q_W-1:0]       q_data;
  cmd_t                 q_cmd;
  logic [SIZE_BITS-1:0] q_size;

  assign block_count_nxt = cfg_we ? cfg_block_count : block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
    end else begin
      block_count_r <= block_count_nxt;
    end
  end

  // Busy simply mirrors a full queue, so the front end keeps taking words
  // while the back end is in the middle of a scan.
  assign busy = q_full;

  ffba_front #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_front (
    .start         (start),
    .q_full        (q_full),
    .in_mode       (in_mode),
    .in_block_slot (in_block_slot),
    .in_size_value (in_size_value),
    .push          (push),
    .cmd           (f_cmd),
    .size          (f_size)
  );

  ffba_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cmd, f_size}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign {q_cmd, q_size} = q_data;

  ffba_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .block_count     (block_count_r),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_size          (q_size),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_granted     (out_granted),
    .out_block_index (out_block_index),
    .out_remaining   (out_remaining)
  );

endmodule

// ===== sv/ffba_front.sv =====
// Front end: accepts command words and classifies them for the queue.
// Depends on ffba_pkg.
module ffba_front #(
  parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = ffba_pkg::DEF_SIZE_BITS
) (
  input  logic                        start,
  input  logic                        q_full,
  input  logic                        in_mode,
  input  logic [ffba_pkg::SLOT_W-1:0] in_block_slot,
  input  logic [ffba_pkg::SIZE_W-1:0] in_size_value,
  output logic                        push,
  output ffba_pkg::cmd_t              cmd,
  output logic [SIZE_BITS-1:0]        size
);
  import ffba_pkg::*;

  // A word is taken whenever the queue has room.
  assign push = start && !q_full;

  always_comb begin
    cmd.op      = (in_mode == MODE_ALLOC) ? MODE_ALLOC : MODE_LOAD;
    // Loads aimed past the end of the table are dropped later.
    cmd.slot_ok = (32'(in_block_slot) < MAX_BLOCKS);
    cmd.slot    = in_block_slot;
  end

  // Sizes are kept modulo 2^SIZE_BITS.
  assign size = SIZE_BITS'(in_size_value);

endmodule

// ===== sv/ffba_queue.sv =====
// Small FIFO that decouples the front end from the back end.
// Depends on ffba_pkg for its default depth.
module ffba_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ffba_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic             full
);
  import ffba_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/ffba_back.sv =====
// Back end: holds the free-capacity table and runs loads and first-fit scans.
// Depends on ffba_pkg.
module ffba_back #(
  parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = ffba_pkg::DEF_SIZE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ffba_pkg::COUNT_W-1:0] block_count,
  input  logic                         q_valid,
  input  ffba_pkg::cmd_t               q_cmd,
  input  logic [SIZE_BITS-1:0]         q_size,
  output logic                         q_pop,
  output logic                         out_strobe,
  output logic                         out_granted,
  output logic [ffba_pkg::SLOT_W-1:0]  out_block_index,
  output logic [ffba_pkg::SIZE_W-1:0]  out_remaining
);
  import ffba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LIM_W = $clog2(MAX_BLOCKS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state_r, state_nxt;
  logic [IDX_W-1:0]     scan_r, scan_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;

  logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] vld_r;
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  logic [LIM_W-1:0]     limit;
  logic [SIZE_BITS-1:0] free;

  logic                 strobe_r, strobe_nxt;
  logic                 granted_r, granted_nxt;
  logic [SLOT_W-1:0]    index_r, index_nxt;
  logic [SIZE_W-1:0]    remain_r, remain_nxt;

  // Blocks past the table size do not exist and are never searched.
  assign limit = (32'(block_count) > MAX_BLOCKS) ? LIM_W'(MAX_BLOCKS)
                                                 : LIM_W'(block_count);

  // Entries never written since reset read as zero capacity.
  assign free = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    state_nxt   = state_r;
    scan_nxt    = scan_r;
    req_nxt     = req_r;
    q_pop       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = scan_r;
    wr_data     = free - req_r;
    strobe_nxt  = 1'b0;
    granted_nxt = 1'b0;
    index_nxt   = '0;
    remain_nxt  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == MODE_LOAD) begin
            wr_en   = q_cmd.slot_ok;
            wr_addr = IDX_W'(q_cmd.slot);
            wr_data = q_size;
          end else begin
            req_nxt  = q_size;
            scan_nxt = '0;
            if (limit == '0) begin
              strobe_nxt = 1'b1;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        rd_addr = scan_r + 1'b1;
        if (req_r <= free) begin
          wr_en       = 1'b1;
          strobe_nxt  = 1'b1;
          granted_nxt = 1'b1;
          index_nxt   = SLOT_W'(scan_r);
          remain_nxt  = SIZE_W'(free - req_r);
          state_nxt   = ST_IDLE;
        end else if (LIM_W'(scan_r) + 1'b1 == limit) begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    req_r     <= req_nxt;
    granted_r <= granted_nxt;
    index_r   <= index_nxt;
    remain_r  <= remain_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_strobe      = strobe_r;
  assign out_granted     = granted_r;
  assign out_block_index = index_r;
  assign out_remaining   = remain_r;

endmodule

// ===== sv/ffba_checker.sv =====
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_mode,
  input logic [ffba_pkg::SLOT_W-1:0]  in_block_slot,
  input logic [ffba_pkg::SIZE_W-1:0]  in_size_value,
  input logic                         out_strobe,
  input logic                         out_granted,
  input logic [ffba_pkg::SLOT_W-1:0]  out_block_index,
  input logic [ffba_pkg::SIZE_W-1:0]  out_remaining,
  input logic                         cfg_we,
  input logic [ffba_pkg::COUNT_W-1:0] cfg_block_count
);
  import ffba_pkg::*;

  // Reset leaves no result pending and the queue empty.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_strobe && !busy))
    else $error("result or busy seen right after reset");

  // The queue only fills up because a word was offered.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a word offered");

  // A refusal carries zero block number and zero capacity.
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_granted) |-> (out_block_index == '0 && out_remaining == '0))
    else $error("refused result carries nonzero fields");

  // A granted block number lies below the value on the cfg_block_count port.
  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_granted) |-> ({1'b0, out_block_index} < cfg_block_count))
    else $error("granted block outside the block count");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

// ===== tb/ffba_checker.sv =====
`timescale 1ns / 100ps
// Checker for the first-fit block allocator: predicts every allocate result and compares.
// Depends on ffba_pkg; instantiated beside the block by tb_first_fit_block_allocator.
module ffba_tb_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         in_mode,
  input  logic [ffba_pkg::SLOT_W-1:0]  in_block_slot,
  input  logic [ffba_pkg::SIZE_W-1:0]  in_size_value,
  input  logic                         out_strobe,
  input  logic                         out_granted,
  input  logic [ffba_pkg::SLOT_W-1:0]  out_block_index,
  input  logic [ffba_pkg::SIZE_W-1:0]  out_remaining,
  input  logic                         cfg_we,
  input  logic [ffba_pkg::COUNT_W-1:0] cfg_block_count,
  output int                           fail_count,
  output int                           pending_count
);
  import ffba_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_BLOCKS;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] block_index;
    logic [SIZE_W-1:0] remaining;
  } grant_t;

  logic [SIZE_W-1:0]  free_cap [TABLE_DEPTH];
  logic [COUNT_W-1:0] blocks_in_use;
  grant_t             expected_grants [$];

  // Scans the blocks in use from zero upward and takes the request from the first that fits.
  function automatic grant_t first_fit_grant(logic [SIZE_W-1:0] request);
    grant_t g;
    int     limit;
    g = '0;
    limit = (blocks_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_in_use);
    for (int j = 0; j < limit; j++) begin
      if (request <= free_cap[j]) begin
        free_cap[j]   = free_cap[j] - request;
        g.granted     = 1'b1;
        g.block_index = j[SLOT_W-1:0];
        g.remaining   = free_cap[j];
        return g;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    grant_t got;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) free_cap[i] = '0;
      blocks_in_use = '0;
      expected_grants.delete();
    end else begin
      if (cfg_we) blocks_in_use = cfg_block_count;
      // A result is always older than a word accepted at the same edge, so check first.
      if (out_strobe) begin
        got = '{out_granted, out_block_index, out_remaining};
        if (expected_grants.size() == 0) begin
          $error("result word with no allocate outstanding");
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (got.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, got.granted);
            fail_count++;
          end
          if (got.block_index !== want.block_index) begin
            $error("block_index: expected %0d, got %0d", want.block_index, got.block_index);
            fail_count++;
          end
          if (got.remaining !== want.remaining) begin
            $error("remaining: expected %0d, got %0d", want.remaining, got.remaining);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_mode == MODE_LOAD) free_cap[in_block_slot] = in_size_value;
        else expected_grants.push_back(first_fit_grant(in_size_value));
      end
    end
    pending_count = expected_grants.size();
  end

endmodule

// ===== tb/tb_first_fit_block_allocator.sv =====
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, stimulus and the final verdict.
// Depends on ffba_pkg, first_fit_block_allocator and ffba_tb_checker.
module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  // Cycles allowed for the back end to finish trailing load words after the last result.
  // Two queued words and a full scan of sixteen blocks fit well inside this.
  localparam int SETTLE_CYCLES = 50;
  localparam int PHASES        = 8;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_mode;
  logic [SLOT_W-1:0]   in_block_slot;
  logic [SIZE_W-1:0]   in_size_value;
  logic                out_strobe;
  logic                out_granted;
  logic [SLOT_W-1:0]   out_block_index;
  logic [SIZE_W-1:0]   out_remaining;
  logic                cfg_we;
  logic [COUNT_W-1:0]  cfg_block_count;
  logic                word_taken;
  int                  fail_count;
  int                  pending_count;

  // The stimulus side keeps the last capacity it loaded into each slot. It ignores what the
  // allocations took away; it only serves to aim requests near real capacities so that exact
  // fits and near misses come up often.
  logic [SIZE_W-1:0]   loaded_cap [DEF_MAX_BLOCKS];

  first_fit_block_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_block_slot   (in_block_slot),
    .in_size_value   (in_size_value),
    .out_strobe      (out_strobe),
    .out_granted     (out_granted),
    .out_block_index (out_block_index),
    .out_remaining   (out_remaining),
    .cfg_we          (cfg_we),
    .cfg_block_count (cfg_block_count)
  );

  ffba_tb_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_block_slot   (in_block_slot),
    .in_size_value   (in_size_value),
    .out_strobe      (out_strobe),
    .out_granted     (out_granted),
    .out_block_index (out_block_index),
    .out_remaining   (out_remaining),
    .cfg_we          (cfg_we),
    .cfg_block_count (cfg_block_count),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  always #5 clk = ~clk;

  // Records at each rising edge whether the word on the input ports was taken, so that the
  // driving code, which runs on the falling edge, never races the block's busy update.
  always @(posedge clk) begin
    word_taken <= start && !busy;
  end

  // Offers one word from a falling edge and returns at the falling edge after it was taken.
  // Start is left high, so a word that follows at once keeps the strobe up without a dip.
  task automatic send_word(logic mode, logic [SLOT_W-1:0] slot, logic [SIZE_W-1:0] size);
    start         <= 1'b1;
    in_mode       <= mode;
    in_block_slot <= slot;
    in_size_value <= size;
    if (mode == MODE_LOAD) loaded_cap[slot] = size;
    do @(negedge clk); while (!word_taken);
  endtask

  // Stops sending and waits until every allocate has been answered, then lets any
  // load words still in the queue or back end finish before the block counts as idle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle, so no word is in flight across the change.
  task automatic write_block_count(logic [COUNT_W-1:0] count);
    cfg_block_count <= count;
    cfg_we          <= 1'b1;
    @(negedge clk);
    cfg_we          <= 1'b0;
  endtask

  // Generous bound on the whole run.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int                 phase_count [PHASES];
    int                 phase_idle  [PHASES];
    int                 phase_words [PHASES];
    int                 pick;
    logic [SLOT_W-1:0]  slot;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;

    // Block count, percentage of cycles the sender idles, and number of random words.
    // A negative count draws a fresh count for that phase.
    phase_count = '{16, 31,  1, -1, 17, -2,  0, 16};
    phase_idle  = '{ 0, 87,  9,  0,  9, 87,  0,  9};
    phase_words = '{150, 120, 80, 120, 120, 110, 30, 80};

    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_LOAD;
    in_block_slot   = '0;
    in_size_value   = '0;
    cfg_we          = 1'b0;
    cfg_block_count = '0;
    for (int i = 0; i < DEF_MAX_BLOCKS; i++) loaded_cap[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. With the whole table searched, the cleared store lets only a zero
    // request through, and that request leaves block zero empty.
    write_block_count(COUNT_W'(16));
    send_word(MODE_ALLOC, 4'd0, 16'h0000);
    send_word(MODE_ALLOC, 4'd0, 16'h0001);
    // Exact fits at both ends of the table and at the largest size.
    send_word(MODE_LOAD,  4'd0,  16'hFFFF);
    send_word(MODE_LOAD,  4'd15, 16'h0010);
    send_word(MODE_ALLOC, 4'd9,  16'hFFFF);
    send_word(MODE_ALLOC, 4'd0,  16'h0010);
    send_word(MODE_ALLOC, 4'd0,  16'h0000);
    // The first fitting block wins even when a later one would fit more tightly.
    send_word(MODE_LOAD,  4'd5,  16'h8000);
    send_word(MODE_LOAD,  4'd10, 16'h7FFF);
    send_word(MODE_ALLOC, 4'd3,  16'h7FFF);
    send_word(MODE_ALLOC, 4'd12, 16'h7FFF);
    send_word(MODE_ALLOC, 4'd6,  16'h0001);
    // Hold off until every answer is back before moving on.
    drain();

    // With no blocks in use every allocate is refused, even a zero request.
    write_block_count(COUNT_W'(0));
    send_word(MODE_ALLOC, 4'd0, 16'h0000);
    send_word(MODE_ALLOC, 4'd0, 16'hFFFF);
    drain();

    // With one block in use, only block zero is searched and block one is out of reach.
    write_block_count(COUNT_W'(1));
    send_word(MODE_LOAD,  4'd0, 16'hAAAA);
    send_word(MODE_LOAD,  4'd1, 16'h5555);
    send_word(MODE_ALLOC, 4'd0, 16'h5555);
    send_word(MODE_ALLOC, 4'd0, 16'h5556);
    drain();

    // A count past the table size searches only the sixteen blocks that exist.
    write_block_count(COUNT_W'(31));
    send_word(MODE_ALLOC, 4'd0, 16'h5555);
    send_word(MODE_ALLOC, 4'd0, 16'h0001);
    send_word(MODE_LOAD,  4'd15, 16'h4000);
    send_word(MODE_ALLOC, 4'd0, 16'h4000);
    drain();

    // Random phases. Each one reloads part of the table and then mixes loads and
    // allocates, with half of the requests aimed at capacities last loaded into the table.
    for (int p = 0; p < PHASES; p++) begin
      if (phase_count[p] == -1) count = COUNT_W'($urandom_range(2, 31));
      else if (phase_count[p] == -2) count = COUNT_W'($urandom_range(2, 15));
      else count = COUNT_W'(phase_count[p]);
      write_block_count(count);

      for (int n = 0; n < phase_words[p]; n++) begin
        while ($urandom_range(99) < phase_idle[p]) begin
          start <= 1'b0;
          @(negedge clk);
        end
        slot = SLOT_W'($urandom_range(DEF_MAX_BLOCKS - 1));
        pick = $urandom_range(15);
        // The first words of a phase are mostly loads so that allocates find real blocks.
        if ((n < 8 && pick < 12) || pick < 6) begin
          pick = $urandom_range(7);
          if (pick < 4) size = SIZE_W'($urandom);
          else if (pick < 6) size = SIZE_W'($urandom_range(255));
          else if (pick == 6) size = '1;
          else size = '0;
          send_word(MODE_LOAD, slot, size);
        end else begin
          pick = $urandom_range(15);
          if (pick < 2) size = '0;
          else if (pick == 2) size = '1;
          else if (pick < 7) size = loaded_cap[SLOT_W'($urandom_range(DEF_MAX_BLOCKS - 1))];
          else if (pick < 11)
            size = SIZE_W'($urandom_range(loaded_cap[SLOT_W'($urandom_range(15))]));
          else if (pick < 13) size = SIZE_W'($urandom_range(63));
          else size = SIZE_W'($urandom);
          // The slot field of an allocate carries random noise; the block must ignore it.
          send_word(MODE_ALLOC, slot, size);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ffba_pkg.sv
sv/ffba_front.sv
sv/ffba_queue.sv
sv/ffba_back.sv
sv/first_fit_block_allocator.sv
sv/ffba_checker.sv
tb/ffba_checker.sv
tb/tb_first_fit_block_allocator.sv
